// ===== rtl/melody_tone_sequencer_defines.svh =====
// Assertion shorthands used by the controller RTL.
`ifndef MELODY_TONE_SEQUENCER_DEFINES_SVH
`define MELODY_TONE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define MTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("melody_tone_sequencer: same-cycle check failed");

// Next-cycle implication, off while reset is held.
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("melody_tone_sequencer: next-cycle check failed");

`endif

// ===== rtl/mts_pkg.sv =====
package mts_pkg;

    localparam int SCORE_DEPTH_DEF = 256;

    localparam int ENTRY_W  = 32;
    localparam int TONE_W   = 16;
    localparam int NOTE_W   = 8;
    localparam int ADDR_W   = 9;   // base plus note before folding
    localparam int VOL_W    = 5;
    localparam int MINT_W   = 15;
    localparam int BASE_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;
    localparam int QUOT_W   = 24;

    localparam logic [QUOT_W-1:0] TIMER_CLOCK = 24'd12000000;
    localparam logic [TONE_W-1:0] MAX_TONE    = 16'd20000;

    localparam logic [VOL_W-1:0]  VOL_RST  = 5'd8;
    localparam logic [MINT_W-1:0] MINT_RST = 15'd131;
    localparam logic [BASE_W-1:0] BASE_RST = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TONE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd2;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_START = 2'd2,
        MODE_STOP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_WAIT     = 2'd0,
        PH_BEGIN    = 2'd1,
        PH_CONTINUE = 2'd2,
        PH_FINISH   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_SILENCE = 2'd1,
        ACT_LOAD    = 2'd2
    } t_action;

    typedef struct packed {
        logic load;
        logic reduce;
        logic ram_we;
        logic ram_re;
        logic div_start;
        logic retire;
    } t_cmd;

    typedef struct packed {
        t_mode  mode;
        t_phase phase;
        logic   addr_ok;
        logic   div_needed;
        logic   div_done;
    } t_status;

endpackage

// ===== rtl/mts_ram.sv =====
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mts_div.sv =====
module mts_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [mts_pkg::TONE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [mts_pkg::QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(mts_pkg::QUOT_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(mts_pkg::QUOT_W - 1);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [mts_pkg::TONE_W-1:0] r_div;
    logic [mts_pkg::TONE_W-1:0] r_rem;
    logic [mts_pkg::QUOT_W-1:0] r_work;
    logic [mts_pkg::TONE_W:0]   w_sh;
    logic                       w_fit;

    // shift in the next dividend bit, take one quotient bit
    assign w_sh  = {r_rem, r_work[mts_pkg::QUOT_W-1]};
    assign w_fit = (w_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_work <= mts_pkg::TIMER_CLOCK;
        end else if (r_busy) begin
            r_rem  <= w_fit ? mts_pkg::TONE_W'(w_sh - {1'b0, r_div})
                            : w_sh[mts_pkg::TONE_W-1:0];
            r_work <= {r_work[mts_pkg::QUOT_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work;

endmodule

// ===== rtl/mts_ctrl.sv =====
`include "melody_tone_sequencer_defines.svh"

module mts_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  mts_pkg::t_status i_status,
    output mts_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_strobe
);

    typedef enum logic [2:0] {
        C_IDLE,
        C_DISPATCH,
        C_ADDR,
        C_READ,
        C_DIV
    } t_cstate;

    t_cstate       r_state;
    t_cstate       n_state;
    logic          r_strobe;
    mts_pkg::t_cmd w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    n_state    = C_DISPATCH;
                end
            end
            C_DISPATCH: begin
                if (i_status.mode == mts_pkg::MODE_WRITE) begin
                    n_state = C_ADDR;
                end else if (i_status.mode == mts_pkg::MODE_TICK &&
                             (i_status.phase == mts_pkg::PH_BEGIN ||
                              i_status.phase == mts_pkg::PH_CONTINUE)) begin
                    n_state = C_ADDR;
                end else begin
                    w_cmd.retire = 1'b1;
                    n_state      = C_IDLE;
                end
            end
            C_ADDR: begin
                if (!i_status.addr_ok) begin
                    w_cmd.reduce = 1'b1;
                end else if (i_status.mode == mts_pkg::MODE_WRITE) begin
                    w_cmd.ram_we = 1'b1;
                    w_cmd.retire = 1'b1;
                    n_state      = C_IDLE;
                end else begin
                    w_cmd.ram_re = 1'b1;
                    n_state      = C_READ;
                end
            end
            C_READ: begin
                if (i_status.phase == mts_pkg::PH_CONTINUE && i_status.div_needed) begin
                    w_cmd.div_start = 1'b1;
                    n_state         = C_DIV;
                end else begin
                    w_cmd.retire = 1'b1;
                    n_state      = C_IDLE;
                end
            end
            C_DIV: begin
                if (i_status.div_done) begin
                    w_cmd.retire = 1'b1;
                    n_state      = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= C_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_cmd.retire;
        end
    end

    assign o_cmd    = w_cmd;
    assign o_busy   = (r_state != C_IDLE);
    assign o_strobe = r_strobe;

    `MTS_ASSERT_NEXT(a_start_dispatch, i_clk, i_rst_n, r_state == C_IDLE && i_start, r_state == C_DISPATCH)
    `MTS_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, r_strobe, r_state == C_IDLE || r_state == C_DISPATCH)
    `MTS_ASSERT_NEXT(a_div_hold, i_clk, i_rst_n, r_state == C_DIV && !i_status.div_done, r_state == C_DIV)
    `MTS_ASSERT_NOW(a_write_only, i_clk, i_rst_n, w_cmd.ram_we, i_status.mode == mts_pkg::MODE_WRITE)

endmodule

// ===== rtl/mts_dp.sv =====
module mts_dp #(
    parameter int SCORE_DEPTH = mts_pkg::SCORE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mts_pkg::t_cmd                 i_cmd,
    output mts_pkg::t_status              o_status,
    input  logic [1:0]                    i_mode,
    input  logic [7:0]                    i_entry_addr,
    input  logic [15:0]                   i_entry_tone,
    input  logic [15:0]                   i_entry_time,
    input  logic                          i_loop_flag,
    input  logic                          i_cfg_we,
    input  logic [mts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mts_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output logic [1:0]                    o_timer_action,
    output logic [15:0]                   o_reload_value,
    output logic [15:0]                   o_compare_value,
    output logic [1:0]                    o_phase,
    output logic [7:0]                    o_note_position
);

    localparam int AW = $clog2(SCORE_DEPTH);
    localparam int DEPTH_BITS = $clog2(SCORE_DEPTH + 1);
    localparam int CMP_W = (DEPTH_BITS > mts_pkg::ADDR_W) ? DEPTH_BITS : mts_pkg::ADDR_W;
    localparam int LEN_MAX = (SCORE_DEPTH - 1 < 255) ? SCORE_DEPTH - 1 : 255;

    // configuration
    logic [mts_pkg::VOL_W-1:0]  r_vol;
    logic [mts_pkg::MINT_W-1:0] r_min_tone;
    logic [mts_pkg::BASE_W-1:0] r_base;

    // play state
    mts_pkg::t_phase r_phase, n_phase;
    logic [mts_pkg::NOTE_W-1:0] r_note, n_note;
    logic [mts_pkg::NOTE_W-1:0] r_len, n_len;
    logic [15:0]                r_ticks, n_ticks;
    logic                       r_loop, n_loop;

    // latched word
    mts_pkg::t_mode              r_mode;
    logic [mts_pkg::ADDR_W-1:0]  r_addr;
    logic [mts_pkg::ENTRY_W-1:0] r_wdata;
    logic                        r_loop_in;

    // result
    mts_pkg::t_action r_act, n_act;
    logic [15:0]      r_reload, n_reload;
    logic [15:0]      r_compare, n_compare;

    logic [mts_pkg::ENTRY_W-1:0] w_rdata;
    logic [15:0]                 w_tone;
    logic [15:0]                 w_dur;
    logic                        w_audible;
    logic                        w_run;
    logic                        w_div_done;
    logic [mts_pkg::QUOT_W-1:0]  w_quot;
    logic [mts_pkg::QUOT_W-1:0]  w_quot_m1;
    logic [15:0]                 w_reload;
    logic [15:0]                 w_dur_m1;
    logic                        w_addr_ok;
    logic [mts_pkg::ADDR_W-1:0]  w_load_addr;

    assign w_tone   = w_rdata[31:16];
    assign w_dur    = w_rdata[15:0];
    assign w_run    = (r_ticks < w_dur);
    assign w_audible = (w_tone != 16'd0) && (w_tone >= {1'b0, r_min_tone}) &&
                       (w_tone <= mts_pkg::MAX_TONE);
    assign w_quot_m1 = w_quot - 1'b1;
    assign w_reload  = (w_quot_m1 > mts_pkg::QUOT_W'(16'hFFFF)) ? 16'hFFFF : w_quot_m1[15:0];
    assign w_dur_m1  = w_dur - 16'd1;
    assign w_addr_ok = (CMP_W'(r_addr) < CMP_W'(SCORE_DEPTH));

    always_comb begin
        if (mts_pkg::t_mode'(i_mode) == mts_pkg::MODE_WRITE) begin
            w_load_addr = mts_pkg::ADDR_W'(i_entry_addr);
        end else if (r_phase == mts_pkg::PH_BEGIN) begin
            w_load_addr = mts_pkg::ADDR_W'(r_base);
        end else begin
            w_load_addr = mts_pkg::ADDR_W'(r_base) + mts_pkg::ADDR_W'(r_note);
        end
    end

    mts_ram #(
        .WIDTH (mts_pkg::ENTRY_W),
        .DEPTH (SCORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_re    (i_cmd.ram_re),
        .i_addr  (AW'(r_addr)),
        .i_wdata (r_wdata),
        .o_rdata (w_rdata)
    );

    mts_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_divisor (w_tone),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    // work out the step's effect on retire
    always_comb begin
        n_phase   = r_phase;
        n_note    = r_note;
        n_len     = r_len;
        n_ticks   = r_ticks;
        n_loop    = r_loop;
        n_act     = mts_pkg::ACT_NONE;
        n_reload  = 16'd0;
        n_compare = 16'd0;
        unique case (r_mode)
            mts_pkg::MODE_START: begin
                n_phase = mts_pkg::PH_BEGIN;
                n_loop  = r_loop_in;
            end
            mts_pkg::MODE_STOP: begin
                n_phase = mts_pkg::PH_FINISH;
                n_loop  = 1'b0;
            end
            mts_pkg::MODE_TICK: begin
                unique case (r_phase)
                    mts_pkg::PH_BEGIN: begin
                        n_len   = (w_dur_m1 > 16'(LEN_MAX)) ? mts_pkg::NOTE_W'(LEN_MAX)
                                                           : w_dur_m1[7:0];
                        n_note  = 8'd1;
                        n_ticks = 16'd0;
                        n_phase = mts_pkg::PH_CONTINUE;
                    end
                    mts_pkg::PH_CONTINUE: begin
                        if (w_run) begin
                            if (r_ticks == 16'd0) begin
                                if (w_audible) begin
                                    n_act     = mts_pkg::ACT_LOAD;
                                    n_reload  = w_reload;
                                    n_compare = w_reload >> r_vol;
                                end else begin
                                    n_act = mts_pkg::ACT_SILENCE;
                                end
                            end
                            n_ticks = r_ticks + 16'd1;
                        end else begin
                            if (r_note < r_len) begin
                                n_note = r_note + 8'd1;
                            end else begin
                                n_act   = mts_pkg::ACT_SILENCE;
                                n_phase = mts_pkg::PH_FINISH;
                            end
                            n_ticks = 16'd0;
                        end
                    end
                    mts_pkg::PH_FINISH: begin
                        n_act   = mts_pkg::ACT_SILENCE;
                        n_note  = 8'd0;
                        n_len   = 8'd0;
                        n_phase = r_loop ? mts_pkg::PH_BEGIN : mts_pkg::PH_WAIT;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol      <= mts_pkg::VOL_RST;
            r_min_tone <= mts_pkg::MINT_RST;
            r_base     <= mts_pkg::BASE_RST;
            r_phase    <= mts_pkg::PH_WAIT;
            r_note     <= '0;
            r_len      <= '0;
            r_ticks    <= '0;
            r_loop     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    mts_pkg::CFG_VOLUME:   r_vol      <= i_cfg_data[mts_pkg::VOL_W-1:0];
                    mts_pkg::CFG_MIN_TONE: r_min_tone <= i_cfg_data;
                    mts_pkg::CFG_BASE:     r_base     <= i_cfg_data[mts_pkg::BASE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.retire) begin
                r_phase <= n_phase;
                r_note  <= n_note;
                r_len   <= n_len;
                r_ticks <= n_ticks;
                r_loop  <= n_loop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= mts_pkg::t_mode'(i_mode);
            r_addr    <= w_load_addr;
            r_wdata   <= {i_entry_tone, i_entry_time};
            r_loop_in <= i_loop_flag;
        end else if (i_cmd.reduce) begin
            // fold the address back into the store
            r_addr <= r_addr - mts_pkg::ADDR_W'(SCORE_DEPTH);
        end
        if (i_cmd.retire) begin
            r_act     <= n_act;
            r_reload  <= n_reload;
            r_compare <= n_compare;
        end
    end

    assign o_status.mode       = r_mode;
    assign o_status.phase      = r_phase;
    assign o_status.addr_ok    = w_addr_ok;
    assign o_status.div_needed = w_run && (r_ticks == 16'd0) && w_audible;
    assign o_status.div_done   = w_div_done;

    assign o_timer_action  = r_act;
    assign o_reload_value  = r_reload;
    assign o_compare_value = r_compare;
    assign o_phase         = r_phase;
    assign o_note_position = r_note;

endmodule

// ===== rtl/melody_tone_sequencer.sv =====
// An accepted word goes to dispatch, which retires start, stop and ticks in wait or finish phase;
// a score write passes the address state, and a tick that reads the score passes the address and
// read states, then the 24-step serial divider when a note begins with a sounding tone. Each fold
// of the address (base plus note at or above the store depth) repeats the address state. The result
// strobe is registered from retire and busy drops as it rises; the receiver cannot stall the result.
// Reset (synchronous, active low) sets wait phase and register defaults; the score is not cleared.
module melody_tone_sequencer #(
    parameter int SCORE_DEPTH = mts_pkg::SCORE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_mode,
    input  logic [7:0]                    i_entry_addr,
    input  logic [15:0]                   i_entry_tone,
    input  logic [15:0]                   i_entry_time,
    input  logic                          i_loop_flag,
    output logic                          o_result_valid,
    output logic [1:0]                    o_timer_action,
    output logic [15:0]                   o_reload_value,
    output logic [15:0]                   o_compare_value,
    output logic [1:0]                    o_phase,
    output logic [7:0]                    o_note_position,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mts_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mts_pkg::CFG_DAT_W-1:0] i_cfg_data
);

    mts_pkg::t_cmd    w_cmd;
    mts_pkg::t_status w_status;
    logic             w_busy;
    logic             w_cfg_we;

    assign busy        = w_busy;
    // hold register writes while a word is in flight or about to be taken
    assign o_cfg_ready = !w_busy && !start;
    assign w_cfg_we    = i_cfg_valid && !w_busy && !start;

    mts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start && !w_busy),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy),
        .o_strobe (o_result_valid)
    );

    mts_dp #(
        .SCORE_DEPTH (SCORE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_mode          (i_mode),
        .i_entry_addr    (i_entry_addr),
        .i_entry_tone    (i_entry_tone),
        .i_entry_time    (i_entry_time),
        .i_loop_flag     (i_loop_flag),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_timer_action  (o_timer_action),
        .o_reload_value  (o_reload_value),
        .o_compare_value (o_compare_value),
        .o_phase         (o_phase),
        .o_note_position (o_note_position)
    );

endmodule
